// File: hw/rtl/qbpg_pkg.sv
// Shared constants, step tables and types for the quadratic Bezier point generator.
`default_nettype none

package qbpg_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int MAX_SEGMENTS_DEF = 63;

  localparam int SEG_W   = 6;   // segment count and point index
  localparam int T_W     = 17;  // Q1.16 parameter, holds 0..65536
  localparam int WGT_W   = 33;  // Q1.32 weight, holds 0..2^32
  localparam int T_ONE   = 65536;
  localparam int N_COORD = 6;   // x0 y0 x1 y1 x2 y2

  localparam logic [SEG_W-1:0] SEG_RESET = 6'd10;
  localparam logic [63:0]      ROUND_HALF = 64'h0000_0000_8000_0000;

  localparam int CURVE_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH   = 8;

  // Per-curve step: t advances by T_ONE / n each point, with the remainder
  // carried so that t = floor(i * T_ONE / n) exactly. Entry 0 is never used.
  localparam logic [T_W-1:0] STEP_Q [64] = '{
    17'd0,             17'(T_ONE / 1),  17'(T_ONE / 2),  17'(T_ONE / 3),
    17'(T_ONE / 4),    17'(T_ONE / 5),  17'(T_ONE / 6),  17'(T_ONE / 7),
    17'(T_ONE / 8),    17'(T_ONE / 9),  17'(T_ONE / 10), 17'(T_ONE / 11),
    17'(T_ONE / 12),   17'(T_ONE / 13), 17'(T_ONE / 14), 17'(T_ONE / 15),
    17'(T_ONE / 16),   17'(T_ONE / 17), 17'(T_ONE / 18), 17'(T_ONE / 19),
    17'(T_ONE / 20),   17'(T_ONE / 21), 17'(T_ONE / 22), 17'(T_ONE / 23),
    17'(T_ONE / 24),   17'(T_ONE / 25), 17'(T_ONE / 26), 17'(T_ONE / 27),
    17'(T_ONE / 28),   17'(T_ONE / 29), 17'(T_ONE / 30), 17'(T_ONE / 31),
    17'(T_ONE / 32),   17'(T_ONE / 33), 17'(T_ONE / 34), 17'(T_ONE / 35),
    17'(T_ONE / 36),   17'(T_ONE / 37), 17'(T_ONE / 38), 17'(T_ONE / 39),
    17'(T_ONE / 40),   17'(T_ONE / 41), 17'(T_ONE / 42), 17'(T_ONE / 43),
    17'(T_ONE / 44),   17'(T_ONE / 45), 17'(T_ONE / 46), 17'(T_ONE / 47),
    17'(T_ONE / 48),   17'(T_ONE / 49), 17'(T_ONE / 50), 17'(T_ONE / 51),
    17'(T_ONE / 52),   17'(T_ONE / 53), 17'(T_ONE / 54), 17'(T_ONE / 55),
    17'(T_ONE / 56),   17'(T_ONE / 57), 17'(T_ONE / 58), 17'(T_ONE / 59),
    17'(T_ONE / 60),   17'(T_ONE / 61), 17'(T_ONE / 62), 17'(T_ONE / 63)
  };

  localparam logic [SEG_W-1:0] STEP_R [64] = '{
    6'd0,           6'(T_ONE % 1),  6'(T_ONE % 2),  6'(T_ONE % 3),
    6'(T_ONE % 4),  6'(T_ONE % 5),  6'(T_ONE % 6),  6'(T_ONE % 7),
    6'(T_ONE % 8),  6'(T_ONE % 9),  6'(T_ONE % 10), 6'(T_ONE % 11),
    6'(T_ONE % 12), 6'(T_ONE % 13), 6'(T_ONE % 14), 6'(T_ONE % 15),
    6'(T_ONE % 16), 6'(T_ONE % 17), 6'(T_ONE % 18), 6'(T_ONE % 19),
    6'(T_ONE % 20), 6'(T_ONE % 21), 6'(T_ONE % 22), 6'(T_ONE % 23),
    6'(T_ONE % 24), 6'(T_ONE % 25), 6'(T_ONE % 26), 6'(T_ONE % 27),
    6'(T_ONE % 28), 6'(T_ONE % 29), 6'(T_ONE % 30), 6'(T_ONE % 31),
    6'(T_ONE % 32), 6'(T_ONE % 33), 6'(T_ONE % 34), 6'(T_ONE % 35),
    6'(T_ONE % 36), 6'(T_ONE % 37), 6'(T_ONE % 38), 6'(T_ONE % 39),
    6'(T_ONE % 40), 6'(T_ONE % 41), 6'(T_ONE % 42), 6'(T_ONE % 43),
    6'(T_ONE % 44), 6'(T_ONE % 45), 6'(T_ONE % 46), 6'(T_ONE % 47),
    6'(T_ONE % 48), 6'(T_ONE % 49), 6'(T_ONE % 50), 6'(T_ONE % 51),
    6'(T_ONE % 52), 6'(T_ONE % 53), 6'(T_ONE % 54), 6'(T_ONE % 55),
    6'(T_ONE % 56), 6'(T_ONE % 57), 6'(T_ONE % 58), 6'(T_ONE % 59),
    6'(T_ONE % 60), 6'(T_ONE % 61), 6'(T_ONE % 62), 6'(T_ONE % 63)
  };

  // Segment plan attached to each curve by the front end.
  typedef struct packed {
    logic [SEG_W-1:0] n;
    logic [T_W-1:0]   step_q;
    logic [SEG_W-1:0] step_r;
  } seg_plan_t;

  localparam int PLAN_W = $bits(seg_plan_t);

endpackage

`default_nettype wire

// File: hw/rtl/quad_bezier_point_generator_unit.sv
// Top level of the quadratic Bezier point generator.
//
// Input channel: one beat is one curve (start, control and end point, signed
// Q12.4). A beat is taken on a rising edge with push high and full low.
// Result channel: each curve yields segments+1 beats of point_x / point_y,
// point_index and last_point (high on the final point, which is the end
// point). The oldest point is shown while empty is low; pop takes it.
// cfg_write / cfg_data load the segment count (0 acts as 1, values above
// MAX_SEGMENTS act as MAX_SEGMENTS); load it only while the block is idle.
// Path: a curve passes the curve queue and the sequencer; its points then run
// through the pipeline stages and the result queue to the result ports.
// Throughput: the back-end sequencer issues one point per cycle while the
// result queue has a reserved slot; the curve queue holds up to two curves
// so intake runs ahead of the back end.
// Reset clears both queues and the sequencer and sets the count to ten.
// When the receiver stalls, points gather in an eight-entry result queue;
// the sequencer holds once every slot is spoken for, and full rises only
// after the curve queue fills behind it. No point is dropped.
`default_nettype none

module quad_bezier_point_generator_unit #(
  parameter int COORD_WIDTH  = qbpg_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = qbpg_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [qbpg_pkg::SEG_W-1:0]        cfg_data,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [COORD_WIDTH-1:0]     start_x,
  input  wire logic signed [COORD_WIDTH-1:0]     start_y,
  input  wire logic signed [COORD_WIDTH-1:0]     ctrl_x,
  input  wire logic signed [COORD_WIDTH-1:0]     ctrl_y,
  input  wire logic signed [COORD_WIDTH-1:0]     end_x,
  input  wire logic signed [COORD_WIDTH-1:0]     end_y,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [COORD_WIDTH-1:0]          point_x,
  output logic signed [COORD_WIDTH-1:0]          point_y,
  output logic        [qbpg_pkg::SEG_W-1:0]      point_index,
  output logic                                   last_point
);

  localparam int W       = COORD_WIDTH;
  localparam int CRV_W   = qbpg_pkg::N_COORD * W;
  localparam int CQ_W    = CRV_W + qbpg_pkg::PLAN_W;
  localparam int OQ_W    = 2 * W + qbpg_pkg::SEG_W + 1;

  logic [CRV_W-1:0]     in_coords;
  logic                 cq_push;
  logic [CRV_W-1:0]     cq_coords_wr;
  qbpg_pkg::seg_plan_t  cq_plan_wr;
  logic [CQ_W-1:0]      cq_rd_data;
  logic                 cq_empty;
  logic                 cq_pop;

  logic                 oq_push;
  logic [W-1:0]         bk_x;
  logic [W-1:0]         bk_y;
  logic [qbpg_pkg::SEG_W-1:0] bk_index;
  logic                 bk_last;
  logic [OQ_W-1:0]      oq_rd_data;
  logic                 oq_full;
  logic                 out_pop;

  // Pack the curve with x0 in the lowest slot.
  assign in_coords = {end_y, end_x, ctrl_y, ctrl_x, start_y, start_x};

  qbpg_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .q_full    (full),
    .coords    (in_coords),
    .q_push    (cq_push),
    .q_coords  (cq_coords_wr),
    .q_plan    (cq_plan_wr)
  );

  // Curve queue between front and back end.
  qbpg_fifo #(
    .WIDTH (CQ_W),
    .DEPTH (qbpg_pkg::CURVE_QUEUE_DEPTH)
  ) u_curve_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_data ({cq_plan_wr, cq_coords_wr}),
    .full    (full),
    .rd_en   (cq_pop),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  qbpg_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_DEPTH   (qbpg_pkg::OUT_QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (cq_empty),
    .q_coords  (cq_rd_data[CRV_W-1:0]),
    .q_plan    (cq_rd_data[CQ_W-1:CRV_W]),
    .q_pop     (cq_pop),
    .out_pop   (out_pop),
    .out_push  (oq_push),
    .out_x     (bk_x),
    .out_y     (bk_y),
    .out_index (bk_index),
    .out_last  (bk_last)
  );

  // Result queue; the back end never pushes into it without a reserved slot,
  // so its full flag only matters as a guard.
  qbpg_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (qbpg_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push && !oq_full),
    .wr_data ({bk_x, bk_y, bk_index, bk_last}),
    .full    (oq_full),
    .rd_en   (out_pop),
    .rd_data (oq_rd_data),
    .empty   (empty)
  );

  assign out_pop     = pop && !empty;
  assign point_x     = oq_rd_data[OQ_W-1 -: W];
  assign point_y     = oq_rd_data[OQ_W-W-1 -: W];
  assign point_index = oq_rd_data[qbpg_pkg::SEG_W:1];
  assign last_point  = oq_rd_data[0];

endmodule

`default_nettype wire

// File: hw/rtl/qbpg_fifo.sv
// Small first-in first-out queue with a registered array and a combinational head.
`default_nettype none

module qbpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qbpg_front.sv
// Front end: segment count register, curve intake, count clamping, step lookup, sign flip.
`default_nettype none

module qbpg_front #(
  parameter int COORD_WIDTH  = qbpg_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = qbpg_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_write,
  input  wire logic [qbpg_pkg::SEG_W-1:0]                 cfg_data,
  input  wire logic                                       push,
  input  wire logic                                       q_full,
  input  wire logic [qbpg_pkg::N_COORD*COORD_WIDTH-1:0]   coords,
  output logic                                            q_push,
  output logic      [qbpg_pkg::N_COORD*COORD_WIDTH-1:0]   q_coords,
  output qbpg_pkg::seg_plan_t                             q_plan
);

  localparam int W = COORD_WIDTH;

  logic [qbpg_pkg::SEG_W-1:0] segment_count;
  logic [qbpg_pkg::SEG_W-1:0] seg_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= qbpg_pkg::SEG_RESET;
    end else if (cfg_write) begin
      segment_count <= cfg_data;
    end
  end

  // Zero acts as one segment; anything above the maximum acts as the maximum.
  always_comb begin
    if (segment_count == '0) begin
      seg_eff = qbpg_pkg::SEG_W'(1);
    end else if (segment_count > qbpg_pkg::SEG_W'(MAX_SEGMENTS)) begin
      seg_eff = qbpg_pkg::SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_eff = segment_count;
    end
  end

  assign q_push        = push && !q_full;
  assign q_plan.n      = seg_eff;
  assign q_plan.step_q = qbpg_pkg::STEP_Q[seg_eff];
  assign q_plan.step_r = qbpg_pkg::STEP_R[seg_eff];

  // Flip the sign bit to move each coordinate to offset binary.
  always_comb begin
    for (int k = 0; k < qbpg_pkg::N_COORD; k++) begin
      q_coords[k*W +: W] = {~coords[k*W + W - 1], coords[k*W +: W-1]};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qbpg_back.sv
// Back end: per-curve point sequencer and the weight / blend pipeline.
`default_nettype none

module qbpg_back #(
  parameter int COORD_WIDTH = qbpg_pkg::COORD_WIDTH_DEF,
  parameter int OUT_DEPTH   = qbpg_pkg::OUT_QUEUE_DEPTH
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     q_empty,
  input  wire logic [qbpg_pkg::N_COORD*COORD_WIDTH-1:0] q_coords,
  input  wire qbpg_pkg::seg_plan_t                      q_plan,
  output logic                                          q_pop,
  input  wire logic                                     out_pop,
  output logic                                          out_push,
  output logic      [COORD_WIDTH-1:0]                   out_x,
  output logic      [COORD_WIDTH-1:0]                   out_y,
  output logic      [qbpg_pkg::SEG_W-1:0]               out_index,
  output logic                                          out_last
);

  localparam int W     = COORD_WIDTH;
  localparam int NC    = qbpg_pkg::N_COORD;
  localparam int SW    = qbpg_pkg::SEG_W;
  localparam int TW    = qbpg_pkg::T_W;
  localparam int WW    = qbpg_pkg::WGT_W;
  localparam int PW    = WW + W;
  localparam int SUM_W = PW + 2;
  localparam int CRD_W = $clog2(OUT_DEPTH + 1);

  // Sequencer state
  logic                busy;
  logic [SW-1:0]       idx;
  logic [TW-1:0]       t_acc;
  logic [SW-1:0]       r_acc;
  logic [W-1:0]        cur_q [NC];
  qbpg_pkg::seg_plan_t cur_plan;
  logic [CRD_W-1:0]    credit;

  logic                issue;
  logic                last_now;
  logic [SW:0]         r_sum;
  logic                r_wrap;

  // Pipeline registers
  logic          s1_valid, s2_valid, s3_valid;
  logic [TW-1:0] s1_t;
  logic [SW-1:0] s1_idx, s2_idx, s3_idx;
  logic          s1_last, s2_last, s3_last;
  logic [W-1:0]  s1_q [NC];
  logic [W-1:0]  s2_q [NC];
  logic [WW-1:0] s2_w [3];
  logic [PW-1:0] s3_p [NC];

  logic [TW-1:0]   s1_u;
  logic [2*TW-1:0] uu, ut, tt;
  logic [SUM_W-1:0] sum_x, sum_y;

  function automatic logic [W-1:0] finish(input logic [SUM_W-1:0] s);
    logic [SUM_W-33:0] r;
    logic [W-1:0]      v;
    r = s[SUM_W-1:32];
    if (|r[SUM_W-33:W]) begin
      v = '1;
    end else begin
      v = r[W-1:0];
    end
    return {~v[W-1], v[W-2:0]};
  endfunction

  // Issue one point a cycle while the output queue has a reserved slot.
  assign issue    = busy && (credit != '0);
  assign last_now = (idx == cur_plan.n);
  assign q_pop    = !q_empty && (!busy || (issue && last_now));

  assign r_sum  = {1'b0, r_acc} + {1'b0, cur_plan.step_r};
  assign r_wrap = (r_sum >= {1'b0, cur_plan.n});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      credit <= CRD_W'(OUT_DEPTH);
    end else begin
      credit <= credit - CRD_W'(issue) + CRD_W'(out_pop);
      if (q_pop) begin
        busy <= 1'b1;
      end else if (issue && last_now) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx      <= '0;
      t_acc    <= '0;
      r_acc    <= '0;
      cur_plan <= q_plan;
      for (int k = 0; k < NC; k++) begin
        cur_q[k] <= q_coords[k*W +: W];
      end
    end else if (issue) begin
      idx   <= idx + 1'b1;
      t_acc <= t_acc + cur_plan.step_q + TW'(r_wrap);
      r_acc <= r_wrap ? SW'(r_sum - {1'b0, cur_plan.n}) : r_sum[SW-1:0];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1: capture t and the curve it belongs to
  always_ff @(posedge clk) begin
    s1_t    <= t_acc;
    s1_idx  <= idx;
    s1_last <= last_now;
    s1_q    <= cur_q;
  end

  // Stage 2: Bernstein weights in Q1.32
  assign s1_u = TW'(qbpg_pkg::T_ONE) - s1_t;
  assign uu   = s1_u * s1_u;
  assign ut   = s1_u * s1_t;
  assign tt   = s1_t * s1_t;

  always_ff @(posedge clk) begin
    s2_w[0] <= uu[WW-1:0];
    s2_w[1] <= {ut[WW-2:0], 1'b0};
    s2_w[2] <= tt[WW-1:0];
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_q    <= s1_q;
  end

  // Stage 3: weight times offset coordinate
  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      s3_p[k] <= PW'(s2_w[k/2]) * PW'(s2_q[k]);
    end
    s3_idx  <= s2_idx;
    s3_last <= s2_last;
  end

  // Sum, round half up, saturate and return to two's complement
  assign sum_x = SUM_W'(s3_p[0]) + SUM_W'(s3_p[2]) + SUM_W'(s3_p[4])
               + SUM_W'(qbpg_pkg::ROUND_HALF);
  assign sum_y = SUM_W'(s3_p[1]) + SUM_W'(s3_p[3]) + SUM_W'(s3_p[5])
               + SUM_W'(qbpg_pkg::ROUND_HALF);

  assign out_push  = s3_valid;
  assign out_x     = finish(sum_x);
  assign out_y     = finish(sum_y);
  assign out_index = s3_idx;
  assign out_last  = s3_last;

endmodule

`default_nettype wire

// File: tb/sv/qbpg_tb_pkg.sv
// Curve and point types plus the point scoreboard used by the Bezier generator bench.
package qbpg_tb_pkg;
  import qbpg_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [CW-1:0] COORD_BIAS = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_LO = {1'b1, {(CW-1){1'b0}}};
  localparam logic [63:0] COORD_TOP = (64'd1 << CW) - 64'd1;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] ctrl_x;
    logic signed [CW-1:0] ctrl_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } curve_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SEG_W-1:0]     index;
    logic                 last;
  } point_t;

  class curve_point_scoreboard;
    point_t           expected_points[$];
    logic [SEG_W-1:0] seg_count;
    int               errors;

    function new();
      seg_count = SEG_RESET;
      errors = 0;
    endfunction

    function void load_segments(logic [SEG_W-1:0] value);
      seg_count = value;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("MISMATCH: %s", msg);
    endtask

    // Weight three offset-binary coordinates, round half up to Q12.4, clamp.
    function logic [CW-1:0] blend_axis(logic [CW-1:0] p0, logic [CW-1:0] p1,
                                       logic [CW-1:0] p2, logic [63:0] w0,
                                       logic [63:0] w1, logic [63:0] w2);
      logic [63:0] acc;
      acc = w0 * p0 + w1 * p1 + w2 * p2;
      acc = (acc + ROUND_HALF) >> 32;
      if (acc > COORD_TOP) acc = COORD_TOP;
      return acc[CW-1:0] ^ COORD_BIAS;
    endfunction

    // Expand one accepted curve into its n+1 points.
    function void note_curve(curve_t c);
      int          n;
      logic [63:0] t;
      logic [63:0] u;
      point_t      p;
      n = (seg_count == 0) ? 1 : int'(seg_count);
      if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
      for (int i = 0; i <= n; i++) begin
        t = (64'(i) * 64'(T_ONE)) / 64'(n);
        u = 64'(T_ONE) - t;
        p.x = blend_axis(c.start_x ^ COORD_BIAS, c.ctrl_x ^ COORD_BIAS,
                         c.end_x ^ COORD_BIAS, u * u, 64'd2 * u * t, t * t);
        p.y = blend_axis(c.start_y ^ COORD_BIAS, c.ctrl_y ^ COORD_BIAS,
                         c.end_y ^ COORD_BIAS, u * u, 64'd2 * u * t, t * t);
        p.index = SEG_W'(i);
        p.last = (i == n);
        expected_points.push_back(p);
      end
    endfunction

    task check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d index=%0d last=%0d",
                         got.x, got.y, got.index, got.last));
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x)
        report($sformatf("point %0d x: got %0d want %0d", want.index, got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("point %0d y: got %0d want %0d", want.index, got.y, want.y));
      if (got.index !== want.index)
        report($sformatf("point index: got %0d want %0d", got.index, want.index));
      if (got.last !== want.last)
        report($sformatf("point %0d last mark: got %0d want %0d",
                         want.index, got.last, want.last));
    endtask
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level bench for the quadratic Bezier point generator: stimulus, checking, end of run.
module tb_top;
  import qbpg_pkg::*;
  import qbpg_tb_pkg::*;

  // Worst case is about 530 curves of 64 points with the receiver stalling
  // about half the time; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT     = 600000;
  localparam int RESET_CYCLES    = 12;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int N_DIRECTED      = 8;
  localparam int DIRECTED_PHASES = 3;
  // Idle time after the last expected point before the next phase starts.
  localparam int SETTLE_CYCLES   = 16;
  localparam int KEEP_COUNT      = -1;
  localparam int RANDOM_COUNT    = -2;
  localparam int PHASE_SEG [N_PHASES] = '{
    KEEP_COUNT, 0, 63, 1, 2, 7, RANDOM_COUNT, RANDOM_COUNT, 63, RANDOM_COUNT
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [SEG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [CW-1:0] start_x = '0;
  logic signed [CW-1:0] start_y = '0;
  logic signed [CW-1:0] ctrl_x = '0;
  logic signed [CW-1:0] ctrl_y = '0;
  logic signed [CW-1:0] end_x = '0;
  logic signed [CW-1:0] end_y = '0;
  logic full;
  logic empty;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic [SEG_W-1:0] point_index;
  logic last_point;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  curve_point_scoreboard curve_points;
  curve_t directed [N_DIRECTED];

  quad_bezier_point_generator_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .start_x     (start_x),
    .start_y     (start_y),
    .ctrl_x      (ctrl_x),
    .ctrl_y      (ctrl_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .empty       (empty),
    .pop         (pop),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_index (point_index),
    .last_point  (last_point)
  );

  always #6 clk = ~clk;

  // Receiver: decide at each falling edge whether to take a beat next edge.
  // rst is driven nonblocking, so this always sees its settled value.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every point beat taken at a rising edge against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      curve_points.check_point(point_t'{point_x, point_y, point_index, last_point});
  end

  // Watchdog: a hung handshake or a missing point ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quad_bezier_point_generator_unit regression: fail");
      $finish;
    end
  end

  // Offer one curve beat, with random idle cycles in front of it. Call right
  // after a falling edge; return right after the falling edge that follows
  // acceptance, leaving push high so back-to-back beats need no toggle.
  task automatic drive_curve(curve_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    start_x <= c.start_x;
    start_y <= c.start_y;
    ctrl_x <= c.ctrl_x;
    ctrl_y <= c.ctrl_y;
    end_x <= c.end_x;
    end_y <= c.end_y;
    @(posedge clk);
    while (full) @(posedge clk);
    curve_points.note_curve(c);
    @(negedge clk);
  endtask

  // Write the segment count; only called with the block idle.
  task automatic load_segments(int value);
    cfg_write <= 1'b1;
    cfg_data <= SEG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    curve_points.load_segments(SEG_W'(value));
    @(negedge clk);
  endtask

  // Hold until every expected point has come out, then let the pipe settle.
  task automatic drain_points();
    while (curve_points.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mix full-range values with the rails, zero and a band around zero so
  // rounding near the half and sign changes both come up often.
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return COORD_HI;
      1: return COORD_LO;
      2: return '0;
      3, 4: return CW'($urandom_range(4095)) - CW'(2048);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.start_x = pick_coord();
    c.start_y = pick_coord();
    c.ctrl_x = pick_coord();
    c.ctrl_y = pick_coord();
    c.end_x = pick_coord();
    c.end_y = pick_coord();
    // Now and then collapse the curve to a single point.
    if ($urandom_range(9) == 0) begin
      c.ctrl_x = c.start_x;
      c.ctrl_y = c.start_y;
      c.end_x = c.start_x;
      c.end_y = c.start_y;
    end
    return c;
  endfunction

  initial begin
    int seg;
    curve_points = new();

    // Extremes of every coordinate, opposite rails pulling against each other,
    // one-LSB wiggles that land on rounding ties, and alternating bit patterns.
    directed[0] = curve_t'{0, 0, 0, 0, 0, 0};
    directed[1] = curve_t'{COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI};
    directed[2] = curve_t'{COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO};
    directed[3] = curve_t'{COORD_LO, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_HI};
    directed[4] = curve_t'{COORD_LO, COORD_LO, 0, 0, COORD_HI, COORD_HI};
    directed[5] = curve_t'{COORD_HI, COORD_LO, COORD_LO, COORD_HI, COORD_LO, COORD_HI};
    directed[6] = curve_t'{1, -1, -1, 1, 1, -1};
    directed[7] = curve_t'{CW'(16'h5555), CW'(16'hAAAA), CW'(16'hAAAA),
                           CW'(16'h5555), CW'(16'h5555), CW'(16'hAAAA)};

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Each phase: set the count (reset value first, then zero acting as one,
    // the maximum, the minimum and assorted values), pick an idling pattern,
    // run the curves and drain before the next register write.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      seg = PHASE_SEG[ph];
      if (seg == RANDOM_COUNT) seg = $urandom_range(3, 62);
      if (seg != KEEP_COUNT) load_segments(seg);
      send_idle_pct = (ph % 4 == 1) ? 46 : (ph % 4 == 3) ? 31 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 31 : 0;
      if (ph < DIRECTED_PHASES)
        foreach (directed[k]) drive_curve(directed[k]);
      repeat (ITEMS_PER_PHASE) drive_curve(random_curve());
      push <= 1'b0;
      drain_points();
    end

    if (curve_points.pending() != 0)
      curve_points.report($sformatf("%0d points never arrived", curve_points.pending()));
    if (curve_points.errors == 0)
      $display("quad_bezier_point_generator_unit regression: pass");
    else
      $display("quad_bezier_point_generator_unit regression: fail");
    $finish;
  end

endmodule
